// File: design/tht_pkg.sv
package tht_pkg;

  localparam int SLOT_COUNT_DEF = 256;
  localparam int INDEX_BITS_DEF = 8;

  localparam int VALUE_W    = 32;
  localparam int OP_W       = 2;
  localparam int ST_W       = 2;
  localparam int SLOT_IDX_W = 8;
  // widest slot address and occupancy count over the parameter range
  localparam int ADDR_W_MAX  = 16;
  localparam int COUNT_W_MAX = 17;

  localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEL  = 2'd1;
  localparam logic [OP_W-1:0] OP_GET  = 2'd2;
  localparam logic [OP_W-1:0] OP_FIND = 2'd3;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd2;
  localparam logic [ST_W-1:0] ST_BADARG  = 2'd3;

  // classified request handed from front to back
  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic                  pre_done;
    logic [ST_W-1:0]       pre_status;
    logic [VALUE_W-1:0]    value;
    logic [VALUE_W-1:0]    tag;
    logic [ADDR_W_MAX-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic                   clearing;
    logic [COUNT_W_MAX-1:0] used_count;
  } back_stat_t;

endpackage

// File: design/tagged_handle_table.sv
// Channel  Handshake            Payload
// input    in_valid / in_stall  operation, entry_value, slot_index, handle
// output   out_valid/out_stall  handle_out, entry_out, status
//
// Add and lookup-by-value read the slot memory one slot per cycle through its
// single read port, up to SLOT_COUNT slots per request. Delete and
// lookup-by-handle take one memory read. Rejected arguments and a full table
// answer without a memory read. After reset a clearing pass zeroes the store,
// with in_stall high. A two-entry queue keeps taking requests while a result
// waits.
module tagged_handle_table #(
  parameter int SLOT_COUNT = tht_pkg::SLOT_COUNT_DEF,
  parameter int INDEX_BITS = tht_pkg::INDEX_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tht_pkg::OP_W-1:0]       operation,
  input  logic [tht_pkg::VALUE_W-1:0]    entry_value,
  input  logic [tht_pkg::SLOT_IDX_W-1:0] slot_index,
  input  logic [tht_pkg::VALUE_W-1:0]    handle,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tht_pkg::VALUE_W-1:0]    handle_out,
  output logic [tht_pkg::VALUE_W-1:0]    entry_out,
  output logic [tht_pkg::ST_W-1:0]       status
);
  import tht_pkg::*;

  cmd_t       cmd;
  logic       cmd_valid;
  logic       cmd_pop;
  back_stat_t stat;

  tht_front #(.SLOT_COUNT(SLOT_COUNT), .INDEX_BITS(INDEX_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .hold        (stat.clearing),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .entry_value (entry_value),
    .slot_index  (slot_index),
    .handle      (handle),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  tht_back #(.SLOT_COUNT(SLOT_COUNT), .INDEX_BITS(INDEX_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .handle_out (handle_out),
    .entry_out  (entry_out),
    .status     (status)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.used_count <= COUNT_W_MAX'(SLOT_COUNT))
    else $error("occupancy count above slot count");

  a_one_field: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (handle_out == '0 || entry_out == '0))
    else $error("handle and entry both set in one result");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (handle_out == '0 && entry_out == '0))
    else $error("failed request carries data");

  a_clear_hold: assert property (@(posedge clk) disable iff (rst)
    stat.clearing |-> !cmd_pop && !out_valid)
    else $error("request served during clearing pass");

endmodule

// File: design/tht_ram.sv
module tht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/tht_front.sv
module tht_front #(
  parameter int SLOT_COUNT = 256,
  parameter int INDEX_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              hold,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tht_pkg::OP_W-1:0]          operation,
  input  logic [tht_pkg::VALUE_W-1:0]       entry_value,
  input  logic [tht_pkg::SLOT_IDX_W-1:0]    slot_index,
  input  logic [tht_pkg::VALUE_W-1:0]       handle,
  output logic                              cmd_valid,
  output tht_pkg::cmd_t                     cmd,
  input  logic                              cmd_pop
);
  import tht_pkg::*;

  localparam logic [VALUE_W-1:0] LOW_MASK = VALUE_W'((64'd1 << INDEX_BITS) - 64'd1);
  localparam logic [VALUE_W-1:0] SLOTS    = VALUE_W'(SLOT_COUNT);

  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  cmd_t       cls;
  logic       push;
  logic [VALUE_W-1:0] hidx;

  assign hidx = handle & LOW_MASK;

  always_comb begin
    cls            = '0;
    cls.op         = operation;
    cls.value      = entry_value;
    cls.tag        = handle & ~LOW_MASK;
    cls.pre_status = ST_OK;
    case (operation)
      OP_ADD: begin
        if (entry_value == '0) begin
          cls.pre_done   = 1'b1;
          cls.pre_status = ST_BADARG;
        end
      end
      OP_DEL: begin
        cls.addr = ADDR_W_MAX'(slot_index);
        if (VALUE_W'(slot_index) >= SLOTS) begin
          cls.pre_done   = 1'b1;
          cls.pre_status = ST_BADARG;
        end
      end
      OP_GET: begin
        cls.addr = ADDR_W_MAX'(hidx);
        if (hidx >= SLOTS) begin
          cls.pre_done   = 1'b1;
          cls.pre_status = ST_MISSING;
        end
      end
      OP_FIND: begin
        if (entry_value == '0) begin
          cls.pre_done   = 1'b1;
          cls.pre_status = ST_BADARG;
        end
      end
      default: begin
        cls.pre_done = 1'b0;
      end
    endcase
  end

  assign in_stall  = (cnt == 2'd2) || hold;
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= cls;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (cmd_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

// File: design/tht_back.sv
module tht_back #(
  parameter int SLOT_COUNT = 256,
  parameter int INDEX_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  input  tht_pkg::cmd_t               cmd,
  output logic                        cmd_pop,
  output tht_pkg::back_stat_t         stat,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tht_pkg::VALUE_W-1:0] handle_out,
  output logic [tht_pkg::VALUE_W-1:0] entry_out,
  output logic [tht_pkg::ST_W-1:0]    status
);
  import tht_pkg::*;

  localparam int AW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam logic [VALUE_W-1:0] LOW_MASK = VALUE_W'((64'd1 << INDEX_BITS) - 64'd1);
  localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(SLOT_COUNT);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0]         state;
  logic [2:0]         state_next;
  cmd_t               cur;
  logic [AW-1:0]      cursor;
  logic [CW-1:0]      used;
  logic [AW-1:0]      clr_addr;
  logic [AW-1:0]      scan_pos;
  logic [AW-1:0]      chk_pos;
  logic [AW-1:0]      cnt;
  logic [VALUE_W-1:0] res_handle;
  logic [VALUE_W-1:0] res_entry;
  logic [ST_W-1:0]    res_status;

  logic               wen;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic [AW-1:0]      raddr;
  logic [VALUE_W-1:0] rdata;
  logic [AW-1:0]      start_pos;
  logic [AW-1:0]      cur_addr;
  logic               hit;
  logic               out_free;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [VALUE_W-1:0] mk_handle(input logic [VALUE_W-1:0] v,
                                                   input logic [AW-1:0] p);
    return (v << INDEX_BITS) | (VALUE_W'(p) & LOW_MASK);
  endfunction

  tht_ram #(.WIDTH(VALUE_W), .DEPTH(SLOT_COUNT)) u_store (
    .clk   (clk),
    .wen   (wen),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cur_addr  = cur.addr[AW-1:0];
  assign start_pos = (cmd.op == OP_ADD) ? cursor : '0;
  assign hit       = (cur.op == OP_ADD) ? (rdata == '0) : (rdata == cur.value);
  assign out_free  = !out_valid || !out_stall;
  assign cmd_pop   = (state == S_IDLE) && cmd_valid;

  always_comb begin
    stat.clearing   = (state == S_CLEAR);
    stat.used_count = COUNT_W_MAX'(used);
  end

  always_comb begin
    raddr = scan_pos;
    if (state == S_IDLE) begin
      raddr = (cmd.op == OP_ADD || cmd.op == OP_FIND) ? start_pos : cmd.addr[AW-1:0];
    end
  end

  always_comb begin
    wen   = 1'b0;
    waddr = chk_pos;
    wdata = '0;
    case (state)
      S_CLEAR: begin
        wen   = 1'b1;
        waddr = clr_addr;
      end
      S_SCAN: begin
        if (hit && cur.op == OP_ADD) begin
          wen   = 1'b1;
          wdata = cur.value;
        end
      end
      S_CHECK: begin
        if (cur.op == OP_DEL && rdata != '0) begin
          wen   = 1'b1;
          waddr = cur_addr;
        end
      end
      default: begin
        wen = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  state_next = (clr_addr == LAST) ? S_IDLE : S_CLEAR;
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.pre_done || (cmd.op == OP_ADD && used >= FULL_COUNT)) begin
            state_next = S_RESULT;
          end else if (cmd.op == OP_ADD || cmd.op == OP_FIND) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_SCAN:   state_next = (hit || cnt == LAST) ? S_RESULT : S_SCAN;
      S_CHECK:  state_next = S_RESULT;
      S_RESULT: state_next = out_free ? S_IDLE : S_RESULT;
      default:  state_next = S_CLEAR;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur        <= cmd;
        scan_pos   <= wrap_inc(start_pos);
        chk_pos    <= start_pos;
        cnt        <= '0;
        res_handle <= '0;
        res_entry  <= '0;
        res_status <= cmd.pre_done ? cmd.pre_status : ST_FULL;
      end
      S_SCAN: begin
        scan_pos <= wrap_inc(scan_pos);
        chk_pos  <= wrap_inc(chk_pos);
        cnt      <= cnt + AW'(1);
        if (hit) begin
          res_handle <= mk_handle(cur.value, chk_pos);
          res_status <= ST_OK;
        end else begin
          res_status <= (cur.op == OP_ADD) ? ST_FULL : ST_MISSING;
        end
      end
      S_CHECK: begin
        if (cur.op == OP_DEL) begin
          res_status <= (rdata != '0) ? ST_OK : ST_MISSING;
        end else if (rdata != '0 && (rdata << INDEX_BITS) == cur.tag) begin
          res_entry  <= rdata;
          res_status <= ST_OK;
        end else begin
          res_status <= ST_MISSING;
        end
      end
      default: begin
        res_status <= res_status;
      end
    endcase
    if (state == S_RESULT && out_free) begin
      handle_out <= res_handle;
      entry_out  <= res_entry;
      status     <= res_status;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      cursor    <= '0;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == S_SCAN && hit && cur.op == OP_ADD) begin
        cursor <= wrap_inc(chk_pos);
        used   <= used + CW'(1);
      end
      if (state == S_CHECK && cur.op == OP_DEL && rdata != '0 && used != '0) begin
        used <= used - CW'(1);
      end
      if (state == S_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
